// ===== src/obb_sat_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Types and constants shared by the separating axis test modules.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

  localparam int XY_W   = 32;   // width of one coordinate field
  localparam int PROJ_W = 63;   // clamped projection, +-2^61

  localparam logic signed [63:0] PROJ_LIM = 64'sh2000_0000_0000_0000;

  // op field of an input item
  localparam logic [1:0] IN_OP_A    = 2'd0;
  localparam logic [1:0] IN_OP_B    = 2'd1;
  localparam logic [1:0] IN_OP_AXIS = 2'd2;

  // sequencer steps within one axis
  localparam logic [4:0] STEP_DRAIN = 5'd16;
  localparam logic [4:0] STEP_EVAL  = 5'd17;
  localparam logic [4:0] STEP_XLO   = 5'd18;
  localparam logic [4:0] STEP_XHI   = 5'd19;
  localparam logic [4:0] STEP_YLO   = 5'd20;
  localparam logic [4:0] STEP_YHI   = 5'd21;
  localparam logic [4:0] STEP_SQX   = 5'd22;
  localparam logic [4:0] STEP_SQY   = 5'd23;
  localparam logic [4:0] STEP_END   = 5'd24;
  localparam logic [1:0] AXIS_LAST  = 2'd3;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } vec_t;

  // multiplier operation issued in one cycle
  typedef enum logic [3:0] {
    MOP_NONE = 4'd0,
    MOP_PX   = 4'd1,
    MOP_PY   = 4'd2,
    MOP_XLO  = 4'd3,
    MOP_XHI  = 4'd4,
    MOP_YLO  = 4'd5,
    MOP_YHI  = 4'd6,
    MOP_SQX  = 4'd7,
    MOP_SQY  = 4'd8
  } mop_t;

  typedef struct packed {
    mop_t       op;
    logic [2:0] corner;    // 0..3 box A, 4..7 box B
    logic [1:0] axis;
    logic       eval;      // check gap and latch overlap
    logic       clear;     // restart best candidate
    logic       load;      // store the accepted input item
    logic       load_out;  // fill the result register
    logic       sep;       // result is separated
  } cmd_t;

  typedef struct packed {
    logic gap;
  } status_t;

endpackage

// ===== src/obb_sat_in_if.sv =====
// ----------------------------------------------------------------------------
// obb_sat_in_if
// Input channel: corner or axis load items.
// ----------------------------------------------------------------------------
interface obb_sat_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         slot;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               last;

  modport source (output valid, op, slot, x_value, y_value, last, input ready);
  modport sink   (input valid, op, slot, x_value, y_value, last, output ready);
endinterface

// ===== src/obb_sat_out_if.sv =====
// ----------------------------------------------------------------------------
// obb_sat_out_if
// Output channel: overlap flag and minimum translation vector.
// ----------------------------------------------------------------------------
interface obb_sat_out_if;
  logic               valid;
  logic               ready;
  logic               overlapping;
  logic signed [31:0] mtv_x;
  logic signed [31:0] mtv_y;

  modport source (output valid, overlapping, mtv_x, mtv_y, input ready);
  modport sink   (input valid, overlapping, mtv_x, mtv_y, output ready);
endinterface

// ===== src/obb_separating_axis_test.sv =====
// ----------------------------------------------------------------------------
// obb_separating_axis_test
// 2D separating axis test between two oriented boxes in signed fixed point.
// ----------------------------------------------------------------------------
//   channel     dir  payload
//   item_in     in   op, slot, x_value, y_value, last
//   result_out  out  overlapping, mtv_x, mtv_y
//
// A load item without last is stored and the block stays ready for the next item.
// An item with last starts the test: each axis runs on the one shared multiplier
// in steps (16 projection products, overlap check, 6 MTV products, two drain
// steps); a full test covers four axes and then fills the result, or ends early
// at the axis that separates the boxes. Items are refused while the test runs; loads are
// taken while a result waits. Reset is synchronous and clears control state.
// ----------------------------------------------------------------------------
module obb_separating_axis_test
  import obb_sat_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst,
  obb_sat_in_if.sink   item_in,
  obb_sat_out_if.source result_out
);

  cmd_t    cmd;
  status_t status;

  obb_sat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_last   (item_in.last),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  obb_sat_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op          (item_in.op),
    .slot        (item_in.slot),
    .x_value     (item_in.x_value),
    .y_value     (item_in.y_value),
    .overlapping (result_out.overlapping),
    .mtv_x       (result_out.mtv_x),
    .mtv_y       (result_out.mtv_y)
  );

endmodule

// ===== src/obb_sat_datapath.sv =====
// ----------------------------------------------------------------------------
// obb_sat_datapath
// Corner and axis storage, one shared 33x33 multiplier with a registered
// product, projection min/max, overlap, saturated MTV and best candidate.
// ----------------------------------------------------------------------------
module obb_sat_datapath
  import obb_sat_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [1:0]         op,
  input  logic [1:0]         slot,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  output logic               overlapping,
  output logic signed [31:0] mtv_x,
  output logic signed [31:0] mtv_y
);

  localparam int COORD_W = (COORD_BITS < 32) ? COORD_BITS : 32;

  function automatic logic signed [PROJ_W-1:0] clamp_proj(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = v;
      if (v > PROJ_LIM) r = PROJ_LIM;
      if (v < -PROJ_LIM) r = -PROJ_LIM;
      return r[PROJ_W-1:0];
    end
  endfunction

  vec_t box_a [4];
  vec_t box_b [4];
  vec_t axes  [4];

  // storage write
  vec_t in_vec;
  assign in_vec.x = 32'(signed'(x_value[COORD_W-1:0]));
  assign in_vec.y = 32'(signed'(y_value[COORD_W-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (op)
        IN_OP_A:    box_a[slot] <= in_vec;
        IN_OP_B:    box_b[slot] <= in_vec;
        IN_OP_AXIS: axes[slot]  <= in_vec;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  vec_t               corner;
  vec_t               axis_v;
  logic [31:0]        abs_ax;
  logic [31:0]        abs_ay;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  logic [PROJ_W-1:1]  ov_mag;
  logic               ov_neg;
  logic               ov_lo_bit;
  logic [30:0]        ov_hi;
  logic [31:0]        mag_x;
  logic               neg_x;
  logic [31:0]        mag_y;
  logic               neg_y;

  assign corner = cmd.corner[2] ? box_b[cmd.corner[1:0]] : box_a[cmd.corner[1:0]];
  assign axis_v = axes[cmd.axis];
  assign abs_ax = axis_v.x[31] ? 32'(-axis_v.x) : 32'(axis_v.x);
  assign abs_ay = axis_v.y[31] ? 32'(-axis_v.y) : 32'(axis_v.y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      MOP_PX: begin
        mul_a = 33'(axis_v.x);
        mul_b = 33'(corner.x);
      end
      MOP_PY: begin
        mul_a = 33'(axis_v.y);
        mul_b = 33'(corner.y);
      end
      MOP_XLO: begin
        mul_a = {1'b0, ov_mag[31:1], 1'b0} | 33'(ov_lo_bit);
        mul_b = {1'b0, abs_ax};
      end
      MOP_XHI: begin
        mul_a = {2'b00, ov_hi};
        mul_b = {1'b0, abs_ax};
      end
      MOP_YLO: begin
        mul_a = {1'b0, ov_mag[31:1], 1'b0} | 33'(ov_lo_bit);
        mul_b = {1'b0, abs_ay};
      end
      MOP_YHI: begin
        mul_a = {2'b00, ov_hi};
        mul_b = {1'b0, abs_ay};
      end
      MOP_SQX: begin
        mul_a = {1'b0, mag_x};
        mul_b = {1'b0, mag_x};
      end
      MOP_SQY: begin
        mul_a = {1'b0, mag_y};
        mul_b = {1'b0, mag_y};
      end
      default: ;
    endcase
  end

  // overlap magnitude kept as bit 0 plus upper bits
  assign ov_hi = ov_mag[PROJ_W-1:32];

  // registered product and the operation it belongs to
  logic signed [65:0] prod;
  mop_t               op_q;
  logic [2:0]         corner_q;
  logic [1:0]         axis_q;

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    corner_q <= cmd.corner;
    axis_q   <= cmd.axis;
    if (rst) begin
      op_q <= MOP_NONE;
    end else begin
      op_q <= cmd.op;
    end
  end

  // projection terms
  logic signed [63:0]       prod_s;
  logic signed [PROJ_W-1:0] term;
  logic signed [PROJ_W-1:0] t_x;
  logic signed [PROJ_W-1:0] proj;
  logic signed [PROJ_W-1:0] a_min;
  logic signed [PROJ_W-1:0] a_max;
  logic signed [PROJ_W-1:0] b_min;
  logic signed [PROJ_W-1:0] b_max;

  assign prod_s = prod[63:0];
  assign term   = clamp_proj(prod_s >>> FRAC_BITS);
  assign proj   = clamp_proj(64'(t_x) + 64'(term));

  always_ff @(posedge clk) begin
    if (op_q == MOP_PX) begin
      t_x <= term;
    end
    if (op_q == MOP_PY) begin
      if (!corner_q[2]) begin
        if (corner_q[1:0] == 2'd0 || proj < a_min) a_min <= proj;
        if (corner_q[1:0] == 2'd0 || proj > a_max) a_max <= proj;
      end else begin
        if (corner_q[1:0] == 2'd0 || proj < b_min) b_min <= proj;
        if (corner_q[1:0] == 2'd0 || proj > b_max) b_max <= proj;
      end
    end
  end

  // gap check and signed overlap
  logic signed [63:0] ov;
  assign status.gap = (b_min > a_max) || (b_max < a_min);
  assign ov = (a_max > b_max) ? (64'(a_min) - 64'(b_max)) : (64'(a_max) - 64'(b_min));

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ov_neg    <= ov[63];
      ov_mag    <= ov[63] ? 62'(64'(-ov) >> 1) : 62'(ov >> 1);
      ov_lo_bit <= ov[0];
    end
  end

  // saturated MTV component from low and high partial products
  localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] LIM_POS  = (64'd1 << (COORD_W - 1));

  logic [63:0] pl;
  logic [63:0] ph;
  logic        neg_c;
  logic [63:0] lim;
  logic [63:0] full;
  logic [63:0] mag;

  assign ph    = prod[63:0];
  assign neg_c = ov_neg ^ ((op_q == MOP_XHI) ? axes[axis_q].x[31] : axes[axis_q].y[31]);
  assign lim   = LIM_POS - {63'd0, ~neg_c};
  assign full  = (ph << (32 - FRAC_BITS)) + (pl >> FRAC_BITS);
  assign mag   = (ph >= FRAC_ONE || full > lim) ? lim : full;

  always_ff @(posedge clk) begin
    if (op_q == MOP_XLO || op_q == MOP_YLO) begin
      pl <= prod[63:0];
    end
    if (op_q == MOP_XHI) begin
      mag_x <= mag[31:0];
      neg_x <= neg_c;
    end
    if (op_q == MOP_YHI) begin
      mag_y <= mag[31:0];
      neg_y <= neg_c;
    end
  end

  // squared magnitude and best candidate; ties keep the earlier axis
  logic [63:0]        sq_x;
  logic [63:0]        mag2;
  logic [63:0]        best;
  logic signed [31:0] best_x;
  logic signed [31:0] best_y;

  assign mag2 = sq_x + prod[63:0];

  always_ff @(posedge clk) begin
    if (op_q == MOP_SQX) begin
      sq_x <= prod[63:0];
    end
    if (cmd.clear) begin
      best <= '1;
    end else if (op_q == MOP_SQY && mag2 < best) begin
      best   <= mag2;
      best_x <= neg_x ? -signed'(mag_x) : signed'(mag_x);
      best_y <= neg_y ? -signed'(mag_y) : signed'(mag_y);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      overlapping <= ~cmd.sep;
      mtv_x       <= cmd.sep ? '0 : best_x;
      mtv_y       <= cmd.sep ? '0 : best_y;
    end
  end

endmodule

// ===== src/obb_sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// obb_sat_ctrl
// Sequencer: loads items, steps four axes through projection, overlap and
// MTV operations, and hands the result to the output register.
// ----------------------------------------------------------------------------
module obb_sat_ctrl
  import obb_sat_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [4:0] step;
  logic [4:0] step_next;
  logic [1:0] axis;
  logic [1:0] axis_next;
  logic       sep;
  logic       sep_next;
  logic       out_valid_next;
  logic       in_accept;
  logic       out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // decode the step into a command
  always_comb begin
    cmd          = '0;
    cmd.op       = MOP_NONE;
    cmd.axis     = axis;
    cmd.corner   = step[3:1];
    cmd.load     = in_accept;
    cmd.clear    = in_accept && in_last;
    cmd.sep      = sep;
    cmd.load_out = (state == ST_FINISH) && out_free;
    if (state == ST_RUN) begin
      case (step)
        STEP_DRAIN: cmd.op = MOP_NONE;
        STEP_EVAL:  cmd.eval = 1'b1;
        STEP_XLO:   cmd.op = MOP_XLO;
        STEP_XHI:   cmd.op = MOP_XHI;
        STEP_YLO:   cmd.op = MOP_YLO;
        STEP_YHI:   cmd.op = MOP_YHI;
        STEP_SQX:   cmd.op = MOP_SQX;
        STEP_SQY:   cmd.op = MOP_SQY;
        STEP_END:   cmd.op = MOP_NONE;
        default:    cmd.op = step[0] ? MOP_PY : MOP_PX;
      endcase
    end
  end

  // advance the sequence
  always_comb begin
    state_next = state;
    step_next  = step;
    axis_next  = axis;
    sep_next   = sep;
    case (state)
      ST_IDLE: begin
        if (in_accept && in_last) begin
          state_next = ST_RUN;
          step_next  = '0;
          axis_next  = '0;
          sep_next   = 1'b0;
        end
      end
      ST_RUN: begin
        if (step == STEP_EVAL && status.gap) begin
          state_next = ST_FINISH;
          sep_next   = 1'b1;
        end else if (step == STEP_END) begin
          step_next = '0;
          if (axis == AXIS_LAST) begin
            state_next = ST_FINISH;
          end else begin
            axis_next = axis + 2'd1;
          end
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold the result until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      axis      <= '0;
      sep       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      axis      <= axis_next;
      sep       <= sep_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_issue_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (cmd.op == MOP_NONE && !cmd.eval))
    else $error("multiplier issued while taking items");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_END)
    else $error("step counter out of range");

  a_gap_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cmd.eval && status.gap) |=> (state == ST_FINISH && sep))
    else $error("separating axis did not end the test");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

endmodule

// ===== tb/obb_sat_checker.sv =====
// ----------------------------------------------------------------------------
// obb_sat_checker
// Watches both channels of the separating axis test, keeps its own copy of the
// loaded corners and axes, predicts each result item and compares in order.
// ----------------------------------------------------------------------------
module obb_sat_checker
  import obb_sat_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  obb_sat_in_if  item_ch,
  obb_sat_out_if result_ch,
  output int     failures,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               overlapping;
    logic signed [31:0] mtv_x;
    logic signed [31:0] mtv_y;
  } sat_result_t;

  localparam logic signed [63:0] PLIM = 64'sh2000_0000_0000_0000;

  vec_t        corners_a [4];
  vec_t        corners_b [4];
  vec_t        axes      [4];
  sat_result_t expected_results[$];

  function automatic logic signed [63:0] clamp_proj(logic signed [63:0] v);
    if (v > PLIM) return PLIM;
    if (v < -PLIM) return -PLIM;
    return v;
  endfunction

  // dot product with floor per term, clamped like the datapath
  function automatic logic signed [63:0] dot_floor(vec_t ax, vec_t c);
    logic signed [63:0] px, py, tx, ty;
    px = 64'(ax.x) * 64'(c.x);
    py = 64'(ax.y) * 64'(c.y);
    tx = clamp_proj(px >>> FRAC_BITS);
    ty = clamp_proj(py >>> FRAC_BITS);
    return clamp_proj(tx + ty);
  endfunction

  // overlap times axis component, toward zero, saturated to 32 bits
  function automatic logic signed [31:0] scale_sat(logic signed [63:0] o,
                                                   logic signed [31:0] a);
    logic signed [127:0] p;
    logic [127:0]        mag;
    logic [127:0]        lim;
    logic                neg;
    p   = 128'(o) * 128'(a);
    neg = p < 0;
    mag = neg ? 128'(-p) : 128'(p);
    mag = mag >> FRAC_BITS;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > lim) mag = lim;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic sat_result_t predict_collision();
    sat_result_t        r;
    logic signed [63:0] a_mn, a_mx, b_mn, b_mx, p, ov;
    logic signed [31:0] mx, my;
    logic [63:0]        ux, uy, mag2, best;
    best = '1;
    r.overlapping = 1'b1;
    r.mtv_x = '0;
    r.mtv_y = '0;
    for (int i = 0; i < 4; i++) begin
      a_mn = dot_floor(axes[i], corners_a[0]);
      a_mx = a_mn;
      b_mn = dot_floor(axes[i], corners_b[0]);
      b_mx = b_mn;
      for (int j = 1; j < 4; j++) begin
        p = dot_floor(axes[i], corners_a[j]);
        if (p < a_mn) a_mn = p;
        if (p > a_mx) a_mx = p;
        p = dot_floor(axes[i], corners_b[j]);
        if (p < b_mn) b_mn = p;
        if (p > b_mx) b_mx = p;
      end
      // a gap on this axis ends the test
      if (b_mn > a_mx || b_mx < a_mn) begin
        r.overlapping = 1'b0;
        r.mtv_x = '0;
        r.mtv_y = '0;
        return r;
      end
      ov = (a_mx > b_mx) ? (a_mn - b_mx) : (a_mx - b_mn);
      mx = scale_sat(ov, axes[i].x);
      my = scale_sat(ov, axes[i].y);
      ux = mx < 0 ? 64'(-64'(mx)) : 64'(mx);
      uy = my < 0 ? 64'(-64'(my)) : 64'(my);
      mag2 = ux * ux + uy * uy;
      // keep the earlier axis on a tie
      if (mag2 < best) begin
        best = mag2;
        r.mtv_x = mx;
        r.mtv_y = my;
      end
    end
    return r;
  endfunction

  always_comb pending = expected_results.size();

  always @(posedge clk) begin
    sat_result_t exp_r;
    vec_t        v;
    if (rst) begin
      failures <= 0;
    end else begin
      // store accepted item, predict on last
      if (item_ch.valid && item_ch.ready) begin
        v.x = item_ch.x_value;
        v.y = item_ch.y_value;
        case (item_ch.op)
          IN_OP_A:    corners_a[item_ch.slot] = v;
          IN_OP_B:    corners_b[item_ch.slot] = v;
          IN_OP_AXIS: axes[item_ch.slot] = v;
          default: ;
        endcase
        if (item_ch.last)
          expected_results.insert(expected_results.size(), predict_collision());
      end
      // compare accepted result with the oldest expectation
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result ovl=%0b x=%0d y=%0d", $realtime,
                   result_ch.overlapping, result_ch.mtv_x, result_ch.mtv_y);
          failures <= failures + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.overlapping !== result_ch.overlapping ||
              exp_r.mtv_x !== result_ch.mtv_x || exp_r.mtv_y !== result_ch.mtv_y) begin
            $display("%0t: mismatch expected ovl=%0b x=%0d y=%0d actual ovl=%0b x=%0d y=%0d",
                     $realtime, exp_r.overlapping, exp_r.mtv_x, exp_r.mtv_y,
                     result_ch.overlapping, result_ch.mtv_x, result_ch.mtv_y);
            failures <= failures + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/obb_separating_axis_test_tb.sv =====
// ----------------------------------------------------------------------------
// obb_separating_axis_test_tb
// Drives corner and axis load sets into the separating axis test, with random
// idling on both channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module obb_separating_axis_test_tb;
  import obb_sat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] IN_OP_NONE = 2'd3;
  localparam int TARGET_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;
  int   idle_cycles;
  bit   hold_request;

  obb_sat_in_if  item_ch ();
  obb_sat_out_if result_ch ();

  obb_separating_axis_test u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  obb_sat_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (item_ch),
    .result_ch (result_ch),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // offer one item and hold it until accepted; entered and left at a falling edge
  task automatic send_item(logic [1:0] op, logic [1:0] slot, logic [31:0] x,
                           logic [31:0] y, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.op      = op;
    item_ch.slot    = slot;
    item_ch.x_value = x;
    item_ch.y_value = y;
    item_ch.last    = last;
    item_ch.valid   = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] near(logic signed [31:0] c, int span);
    return c + $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [31:0] axis_comp(int mode);
    if (mode == 0) return $urandom;
    return $signed($urandom_range(2 * 65536 * 2)) - 65536 * 2;
  endfunction

  // load a full or partial set with random content and run the test
  task automatic run_set();
    int          mode, order_base, noise;
    logic [31:0] cx, cy;
    logic [3:0]  idx;
    logic [1:0]  op;
    mode = $urandom_range(9);
    cx = (mode == 0) ? $urandom : near(0, 1 << 20);
    cy = (mode == 0) ? $urandom : near(0, 1 << 20);
    order_base = $urandom_range(11);
    for (int k = 0; k < 12; k++) begin
      // broken sequence: end the set early
      if (mode == 9 && k > 2 && $urandom_range(7) == 0) break;
      idx = 4'((order_base + k) % 12);
      op  = 2'(idx / 4);
      noise = $urandom_range(15);
      if (noise == 0)
        send_item(IN_OP_NONE, 2'($urandom), $urandom, $urandom, 1'b0);
      if (op == IN_OP_AXIS)
        send_item(op, idx[1:0], axis_comp(mode == 0 || mode == 1),
                  axis_comp(mode == 0 || mode == 1), k == 11);
      else if (mode == 1)
        send_item(op, idx[1:0], $urandom, $urandom, k == 11);
      else
        send_item(op, idx[1:0], near(cx + (op == IN_OP_B ? (mode << 17) : 0), 1 << 17),
                  near(cy, 1 << 17), k == 11);
    end
    if (mode == 9) send_item(2'($urandom), 2'($urandom), $urandom, $urandom, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    hold_request = 1'b0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    item_ch.valid = 1'b0;
    item_ch.op = IN_OP_A;
    item_ch.slot = '0;
    item_ch.x_value = '0;
    item_ch.y_value = '0;
    item_ch.last = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // overlapping unit squares, offset by half
    for (int s = 0; s < 4; s++) begin
      send_item(IN_OP_A, 2'(s), s[0] ? 32'h1_0000 : 0, s[1] ? 32'h1_0000 : 0, 1'b0);
      send_item(IN_OP_B, 2'(s), s[0] ? 32'h1_8000 : 32'h8000, s[1] ? 32'h1_0000 : 0,
                1'b0);
    end
    send_item(IN_OP_AXIS, 2'd0, 32'h1_0000, 0, 1'b0);
    send_item(IN_OP_AXIS, 2'd1, 0, 32'h1_0000, 1'b0);
    send_item(IN_OP_AXIS, 2'd2, 32'h1_0000, 0, 1'b0);
    send_item(IN_OP_AXIS, 2'd3, 0, 32'h1_0000, 1'b1);
    // move B far away: separated
    for (int s = 0; s < 4; s++)
      send_item(IN_OP_B, 2'(s), 32'h10_0000 + (s[0] ? 32'h1_0000 : 0),
                s[1] ? 32'h1_0000 : 0, s == 3);
    // field extremes, saturating MTV
    send_item(IN_OP_A, 2'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_item(IN_OP_B, 2'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_item(IN_OP_AXIS, 2'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_item(IN_OP_AXIS, 2'd1, 32'hffff_ffff, 32'h8000_0000, 1'b1);
    // unknown op still runs the test
    send_item(IN_OP_NONE, 2'd2, 32'hffff_ffff, 32'hffff_ffff, 1'b1);

    // idling phases, long receiver hold-off in the first
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 19 : 0;
      if (ph == 0) hold_request = 1'b1;
      while (items_sent < TARGET_ITEMS * (ph + 1) / 4) run_set();
    end
    item_ch.valid = 1'b0;

    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
